// ===== rtl/joystick_drive_command_decoder_unit_assert.svh =====
// Assertion macros used by the decoder RTL.
`ifndef JOYSTICK_DRIVE_COMMAND_DECODER_UNIT_ASSERT_SVH
`define JOYSTICK_DRIVE_COMMAND_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JDCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define JDCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/jdcd_pkg.sv =====
package jdcd_pkg;

   localparam int COORD_BITS_DEF = 10;

   localparam int MAP_OFFSET = 98;
   localparam int DUTY_MAX   = 100;

   localparam logic [2:0] SEP_LIMIT = 3'd4;
   localparam logic [2:0] SEP_VALID = 3'd3;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_END    = 8'h24;  // '$'
   localparam logic [7:0] CHAR_ARM_ON = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_ARM_OFF = 8'h42; // 'B'

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   typedef struct packed {
      logic done;       // byte was the frame terminator
      logic err;        // terminator with a bad separator count
      logic apply;      // terminator of a well-formed frame
      logic brush_on;
      logic brush_off;
   } frame_evt_type;

endpackage

// ===== rtl/joystick_drive_command_decoder_unit.sv =====
// Path: an accepted req is held in the input register, then moves into the result register.
// Throughput: one item per cycle; the single decode pass from the input register
// into the frame and drive registers sets that rate, and rsp_ready back-pressure stalls it.
// Reset (synchronous, active high) clears the frame parser, stops both wheels,
// sets duties to zero, turns brushes and fan off and empties both registers.
module joystick_drive_command_decoder_unit #(
   parameter int COORD_BITS = jdcd_pkg::COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_drive_dir,
   output logic [6:0] rsp_left_duty,
   output logic [6:0] rsp_right_duty,
   output logic       rsp_side_brushes_on,
   output logic       rsp_fan_on,
   output logic       rsp_frame_done,
   output logic       rsp_frame_error
);
   import jdcd_pkg::*;

   `include "joystick_drive_command_decoder_unit_assert.svh"

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  done_ff, done_in;
   logic                  err_ff, err_in;
   logic                  advance;
   frame_evt_type         evt;
   logic [COORD_BITS-1:0] x_coord, y_coord;
   dir_type               drive_dir;

   jdcd_frame #(.COORD_BITS(COORD_BITS)) u_frame (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (byte_ff),
      .evt     (evt),
      .x_coord (x_coord),
      .y_coord (y_coord)
   );

   jdcd_drive #(.COORD_BITS(COORD_BITS)) u_drive (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .evt        (evt),
      .x_coord    (x_coord),
      .y_coord    (y_coord),
      .drive_dir  (drive_dir),
      .left_duty  (rsp_left_duty),
      .right_duty (rsp_right_duty),
      .brush_on   (rsp_side_brushes_on),
      .fan_on     (rsp_fan_on)
   );

   // item moves from the input register into the result register
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      byte_in      = byte_ff;
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      done_in      = done_ff;
      err_in       = err_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         byte_in     = req_rx_byte;
         in_valid_in = 1'b1;
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         done_in      = evt.done;
         err_in       = evt.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff <= byte_in;
      done_ff <= done_in;
      err_ff  <= err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_dir   = drive_dir;
   assign rsp_frame_done  = done_ff;
   assign rsp_frame_error = err_ff;

   `JDCD_ASSERT_NOW(a_err_needs_done, clock, reset, rsp_valid && rsp_frame_error,
      rsp_frame_done, "frame_error without frame_done")
   `JDCD_ASSERT_NOW(a_duty_range, clock, reset, rsp_valid,
      (rsp_left_duty <= 7'd100) && (rsp_right_duty <= 7'd100), "duty above 100")
   `JDCD_ASSERT_NOW(a_stop_zero, clock, reset, drive_dir == DIR_STOP,
      (rsp_left_duty == 7'd0) && (rsp_right_duty == 7'd0), "stopped with nonzero duty")
   `JDCD_ASSERT_NOW(a_brush_fan, clock, reset, 1'b1,
      rsp_side_brushes_on == rsp_fan_on, "brushes and fan disagree")
   `JDCD_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready,
      $stable(drive_dir) && $stable(rsp_left_duty) && $stable(rsp_frame_done),
      "result changed while stalled")

endmodule

// ===== rtl/jdcd_frame.sv =====
module jdcd_frame #(
   parameter int COORD_BITS = jdcd_pkg::COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   output jdcd_pkg::frame_evt_type evt,
   output logic [COORD_BITS-1:0]   x_coord,
   output logic [COORD_BITS-1:0]   y_coord
);
   import jdcd_pkg::*;

   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

   logic [2:0]            sep_count_ff, sep_count_in;
   logic [COORD_BITS-1:0] x_ff, x_in;
   logic [COORD_BITS-1:0] y_ff, y_in;
   logic                  is_digit;
   logic [3:0]            digit;
   logic [2:0]            sep_next;

   function automatic logic [COORD_BITS-1:0] acc_digit(input logic [COORD_BITS-1:0] acc,
                                                       input logic [3:0] d);
      logic [COORD_BITS+3:0] n;
      n = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{COORD_BITS{1'b0}}, d};
      if (n > {4'b0, COORD_MAX}) begin
         return COORD_MAX;
      end
      return n[COORD_BITS-1:0];
   endfunction

   always_comb begin
      is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
      digit    = rx_byte[3:0];  // '0'..'9' are 0x30..0x39
      x_in     = x_ff;
      y_in     = y_ff;
      sep_next = sep_count_ff;
      if (is_digit) begin
         if (sep_count_ff == 3'd1) begin
            x_in = acc_digit(x_ff, digit);
         end else if (sep_count_ff == 3'd2) begin
            y_in = acc_digit(y_ff, digit);
         end
      end else if (sep_count_ff < SEP_LIMIT) begin
         sep_next = sep_count_ff + 3'd1;
      end
      sep_count_in = sep_next;

      evt.done      = (rx_byte == CHAR_END);
      evt.apply     = evt.done && (sep_next == SEP_VALID);
      evt.err       = evt.done && (sep_next != SEP_VALID);
      evt.brush_on  = (rx_byte == CHAR_ARM_ON);
      evt.brush_off = (rx_byte == CHAR_ARM_OFF);

      if (evt.done || evt.brush_on || evt.brush_off) begin
         sep_count_in = '0;
         x_in         = '0;
         y_in         = '0;
      end
   end

   // terminator is not a digit, so the stored coordinates are the final ones
   assign x_coord = x_ff;
   assign y_coord = y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_count_ff <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
      end else if (step) begin
         sep_count_ff <= sep_count_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
      end
   end

endmodule

// ===== rtl/jdcd_drive.sv =====
module jdcd_drive #(
   parameter int COORD_BITS = jdcd_pkg::COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  jdcd_pkg::frame_evt_type evt,
   input  logic [COORD_BITS-1:0]   x_coord,
   input  logic [COORD_BITS-1:0]   y_coord,
   output jdcd_pkg::dir_type       drive_dir,
   output logic [6:0]              left_duty,
   output logic [6:0]              right_duty,
   output logic                    brush_on,
   output logic                    fan_on
);
   import jdcd_pkg::*;

   localparam int W = COORD_BITS + 3;

   dir_type           dir_ff, dir_in;
   logic [6:0]        left_ff, left_in;
   logic [6:0]        right_ff, right_in;
   logic              brush_ff, brush_in;
   logic              fan_ff, fan_in;
   logic signed [W-1:0] xm, ym;
   logic              x_pos, x_neg, y_pos, y_neg;

   function automatic logic [6:0] clamp_pct(input logic signed [W-1:0] v);
      if (v[W-1]) begin
         return 7'd0;
      end
      if (v > $signed(W'(DUTY_MAX))) begin
         return 7'(DUTY_MAX);
      end
      return v[6:0];
   endfunction

   always_comb begin
      xm    = $signed({2'b0, x_coord, 1'b0}) - $signed(W'(MAP_OFFSET));
      ym    = $signed({2'b0, y_coord, 1'b0}) - $signed(W'(MAP_OFFSET));
      x_neg = xm[W-1];
      y_neg = ym[W-1];
      x_pos = !x_neg && (xm != '0);
      y_pos = !y_neg && (ym != '0);

      dir_in   = dir_ff;
      left_in  = left_ff;
      right_in = right_ff;
      brush_in = brush_ff;
      fan_in   = fan_ff;

      if (evt.apply) begin
         if (x_pos && y_neg) begin
            dir_in   = DIR_FWD;
            left_in  = clamp_pct(-ym);
            right_in = clamp_pct(-ym - xm);
         end else if (x_pos && y_pos) begin
            dir_in   = DIR_REV;
            left_in  = clamp_pct(ym);
            right_in = clamp_pct(ym - xm);
         end else if (x_neg && y_pos) begin
            dir_in   = DIR_REV;
            left_in  = clamp_pct(ym + xm);
            right_in = clamp_pct(ym);
         end else if (x_neg && y_neg) begin
            dir_in   = DIR_FWD;
            left_in  = clamp_pct(xm - ym);
            right_in = clamp_pct(-ym);
         end else if (!x_pos && !x_neg && !y_pos && !y_neg) begin
            dir_in   = DIR_STOP;
            left_in  = '0;
            right_in = '0;
         end
         // one axis centered: drive holds
      end

      if (evt.brush_on) begin
         brush_in = 1'b1;
         fan_in   = 1'b1;
      end else if (evt.brush_off) begin
         brush_in = 1'b0;
         fan_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= DIR_STOP;
         left_ff  <= '0;
         right_ff <= '0;
         brush_ff <= 1'b0;
         fan_ff   <= 1'b0;
      end else if (step) begin
         dir_ff   <= dir_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         brush_ff <= brush_in;
         fan_ff   <= fan_in;
      end
   end

   assign drive_dir  = dir_ff;
   assign left_duty  = left_ff;
   assign right_duty = right_ff;
   assign brush_on   = brush_ff;
   assign fan_on     = fan_ff;

endmodule
